// ----- hw/rtl/psat_pkg.sv -----
// ----------------------------------------------------------------------------
// psat_pkg
// Shared widths, register indexes and pipeline control types for the
// point sprite affine transform.
// ----------------------------------------------------------------------------
package psat_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int SIZE_W  = 21;
    localparam int ALPHA_W = 17;
    localparam int COS_W   = 21;
    localparam int SCALE_W = 20;

    // pos_x, pos_y, vel_x, vel_y, angle, size, alpha
    localparam int FIELDS_W = 4 * COORD_W + ANGLE_W + SIZE_W + ALPHA_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ALPHA_ONE = 65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS      = 3'd0,
        CFG_SIN_DIV  = 3'd1,
        CFG_SIN_MUL  = 3'd2,
        CFG_SCALE    = 3'd3,
        CFG_ROTATION = 3'd4,
        CFG_OPACITY  = 3'd5,
        CFG_OFFSET_X = 3'd6,
        CFG_OFFSET_Y = 3'd7
    } t_cfg_idx;

    // load enables of pipeline stages 2 to 5
    typedef struct packed {
        logic en_s2;
        logic en_s3;
        logic en_s4;
        logic en_s5;
    } t_pipe_ctl;

endpackage

// ----- hw/rtl/psat_lane.sv -----
// ----------------------------------------------------------------------------
// psat_lane
// One transformed coordinate: a*u +/- b*w, rounded to nearest, plus bias,
// saturated to 32 bits. Four register stages.
// ----------------------------------------------------------------------------
module psat_lane #(
    parameter int FRACTION_BITS = psat_pkg::FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  psat_pkg::t_pipe_ctl  i_ctl,
    input  logic                 i_sub,
    input  logic signed [31:0]   i_coef_a,
    input  logic signed [31:0]   i_coef_b,
    input  logic signed [32:0]   i_u,
    input  logic signed [32:0]   i_w,
    input  logic signed [32:0]   i_bias,
    output logic [31:0]          o_res
);

    localparam logic signed [65:0] RND     = 66'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [66:0] SAT_MAX = 67'(32'sh7fff_ffff);
    localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

    logic signed [64:0] r_pa, r_pb, n_pa, n_pb;
    logic signed [65:0] r_sum, n_sum;
    logic signed [65:0] n_rnd;
    logic signed [66:0] r_val, n_val;
    logic [31:0]        r_res, n_res;

    always_comb begin
        n_pa  = 65'(i_coef_a) * 65'(i_u);
        n_pb  = 65'(i_coef_b) * 65'(i_w);
        n_sum = i_sub ? (66'(r_pa) - 66'(r_pb)) : (66'(r_pa) + 66'(r_pb));
        n_rnd = (r_sum + RND) >>> FRACTION_BITS;
        n_val = 67'(n_rnd) + 67'(i_bias);
        if (r_val > SAT_MAX) begin
            n_res = 32'h7fff_ffff;
        end else if (r_val < SAT_MIN) begin
            n_res = 32'h8000_0000;
        end else begin
            n_res = r_val[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_ctl.en_s3) begin
            r_sum <= n_sum;
        end
        if (i_ctl.en_s4) begin
            r_val <= n_val;
        end
        if (i_ctl.en_s5) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/point_sprite_affine_transform_top.sv -----
// Throughput: one item per cycle while i_m_tready is high; a stalled output fills empty stages first.
// Pipeline stages: input capture, the 32x33 multiply, the sum, round/offset and saturate.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// register defaults: unity scale and opacity, no rotation, no offset.
// ----------------------------------------------------------------------------
// point_sprite_affine_transform_top
// Rotates, scales and translates particle points about the centre, with
// angle wrap, size scaling and alpha gain. Streaming in and out.
// ----------------------------------------------------------------------------
module point_sprite_affine_transform_top #(
    parameter int FRACTION_BITS = psat_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pos_x, pos_y, vel_x, vel_y, angle, sprite_size, alpha, zero pad
    input  logic [psat_pkg::TDATA_W-1:0]        i_s_tdata,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tlast,
    output logic                                o_s_tready,
    // new_x, new_y, new_vel_x, new_vel_y, new_angle, new_size, new_alpha, pad
    output logic [psat_pkg::TDATA_W-1:0]        o_m_tdata,
    output logic                                o_m_tvalid,
    output logic                                o_m_tlast,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psat_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psat_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = psat_pkg::COORD_W;
    localparam int AW = psat_pkg::ANGLE_W;
    localparam int SW = psat_pkg::SIZE_W;
    localparam int LW = psat_pkg::ALPHA_W;
    localparam int FW = psat_pkg::FIELDS_W;
    localparam int PW = psat_pkg::SIZE_W + psat_pkg::SCALE_W;
    localparam int QW = 2 * psat_pkg::ALPHA_W;

    localparam int ANG_LO   = 4 * CW;
    localparam int SIZE_LO  = ANG_LO + AW;
    localparam int ALPHA_LO = SIZE_LO + SW;

    localparam logic signed [32:0] HALF      = 33'(1) <<< (FRACTION_BITS - 1);
    localparam logic [PW:0]        SZ_RND    = (PW + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic [PW:0]        SZ_LIMIT  = (PW + 1)'(16) << FRACTION_BITS;
    localparam logic [QW:0]        AL_RND    = (QW + 1)'(32768);
    localparam logic [QW:0]        AL_LIMIT  = (QW + 1)'(psat_pkg::ALPHA_ONE);

    // configuration registers
    logic signed [psat_pkg::COS_W-1:0]   r_cos;
    logic signed [31:0]                  r_sin_div;
    logic signed [31:0]                  r_sin_mul;
    logic [psat_pkg::SCALE_W-1:0]        r_scale;
    logic [AW-1:0]                       r_rot;
    logic [LW-1:0]                       r_opacity;
    logic signed [31:0]                  r_off_x;
    logic signed [31:0]                  r_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos     <= psat_pkg::COS_W'(1) << FRACTION_BITS;
            r_sin_div <= '0;
            r_sin_mul <= '0;
            r_scale   <= psat_pkg::SCALE_W'(1) << FRACTION_BITS;
            r_rot     <= '0;
            r_opacity <= LW'(psat_pkg::ALPHA_ONE);
            r_off_x   <= '0;
            r_off_y   <= '0;
        end else if (i_cfg_valid) begin
            case (psat_pkg::t_cfg_idx'(i_cfg_index))
                psat_pkg::CFG_COS:      r_cos     <= i_cfg_data[psat_pkg::COS_W-1:0];
                psat_pkg::CFG_SIN_DIV:  r_sin_div <= i_cfg_data;
                psat_pkg::CFG_SIN_MUL:  r_sin_mul <= i_cfg_data;
                psat_pkg::CFG_SCALE:    r_scale   <= i_cfg_data[psat_pkg::SCALE_W-1:0];
                psat_pkg::CFG_ROTATION: r_rot     <= i_cfg_data[AW-1:0];
                psat_pkg::CFG_OPACITY:  r_opacity <= i_cfg_data[LW-1:0];
                psat_pkg::CFG_OFFSET_X: r_off_x   <= i_cfg_data;
                psat_pkg::CFG_OFFSET_Y: r_off_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en_s1;
    psat_pkg::t_pipe_ctl ctl;

    always_comb begin
        ctl.en_s5 = !r_v5 || i_m_tready;
        ctl.en_s4 = !r_v4 || ctl.en_s5;
        ctl.en_s3 = !r_v3 || ctl.en_s4;
        ctl.en_s2 = !r_v2 || ctl.en_s3;
        en_s1     = !r_v1 || ctl.en_s2;
    end

    assign o_s_tready = en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en_s1)     r_v1 <= i_s_tvalid;
            if (ctl.en_s2) r_v2 <= r_v1;
            if (ctl.en_s3) r_v3 <= r_v2;
            if (ctl.en_s4) r_v4 <= r_v3;
            if (ctl.en_s5) r_v5 <= r_v4;
        end
    end

    // stage 1: input capture, centre removed from position
    logic signed [32:0] r1_px, r1_py, r1_vx, r1_vy;
    logic [AW-1:0]      r1_ang;
    logic [SW-1:0]      r1_size;
    logic [LW-1:0]      r1_alpha;
    logic               r1_last;

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r1_px    <= 33'(signed'(i_s_tdata[CW-1:0])) - HALF;
            r1_py    <= 33'(signed'(i_s_tdata[2*CW-1:CW])) - HALF;
            r1_vx    <= 33'(signed'(i_s_tdata[3*CW-1:2*CW]));
            r1_vy    <= 33'(signed'(i_s_tdata[4*CW-1:3*CW]));
            r1_ang   <= i_s_tdata[SIZE_LO-1:ANG_LO];
            r1_size  <= i_s_tdata[ALPHA_LO-1:SIZE_LO];
            r1_alpha <= i_s_tdata[FW-1:ALPHA_LO];
            r1_last  <= i_s_tlast;
        end
    end

    // affine lanes
    logic signed [31:0] cos_ext;
    logic signed [32:0] bias_x, bias_y;
    logic [31:0]        res_x, res_y, res_vx, res_vy;

    assign cos_ext = 32'(r_cos);
    assign bias_x  = HALF + 33'(r_off_x);
    assign bias_y  = HALF + 33'(r_off_y);

    psat_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_x (
        .i_clk(i_clk), .i_ctl(ctl), .i_sub(1'b1),
        .i_coef_a(cos_ext), .i_coef_b(r_sin_div), .i_u(r1_px), .i_w(r1_py),
        .i_bias(bias_x), .o_res(res_x)
    );

    psat_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_y (
        .i_clk(i_clk), .i_ctl(ctl), .i_sub(1'b0),
        .i_coef_a(r_sin_mul), .i_coef_b(cos_ext), .i_u(r1_px), .i_w(r1_py),
        .i_bias(bias_y), .o_res(res_y)
    );

    psat_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_vx (
        .i_clk(i_clk), .i_ctl(ctl), .i_sub(1'b1),
        .i_coef_a(cos_ext), .i_coef_b(r_sin_div), .i_u(r1_vx), .i_w(r1_vy),
        .i_bias(33'sd0), .o_res(res_vx)
    );

    psat_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_vy (
        .i_clk(i_clk), .i_ctl(ctl), .i_sub(1'b0),
        .i_coef_a(r_sin_mul), .i_coef_b(cos_ext), .i_u(r1_vx), .i_w(r1_vy),
        .i_bias(33'sd0), .o_res(res_vy)
    );

    // angle, size and alpha side path
    logic [AW-1:0] r2_ang, r3_ang, r4_ang, r5_ang;
    logic [PW-1:0] r2_size_p;
    logic [QW-1:0] r2_alpha_p;
    logic [SW-1:0] r3_size, r4_size, r5_size, n3_size;
    logic [LW-1:0] r3_alpha, r4_alpha, r5_alpha, n3_alpha;
    logic          r2_last, r3_last, r4_last, r5_last;
    logic [PW:0]   sz_round;
    logic [QW:0]   al_round;

    always_comb begin
        sz_round = ((PW + 1)'(r2_size_p) + SZ_RND) >> FRACTION_BITS;
        al_round = ((QW + 1)'(r2_alpha_p) + AL_RND) >> 16;
        n3_size  = (sz_round > SZ_LIMIT) ? SZ_LIMIT[SW-1:0] : sz_round[SW-1:0];
        n3_alpha = (al_round > AL_LIMIT) ? AL_LIMIT[LW-1:0] : al_round[LW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en_s2) begin
            r2_ang     <= r1_ang + r_rot;
            r2_size_p  <= PW'(r1_size) * PW'(r_scale);
            r2_alpha_p <= QW'(r1_alpha) * QW'(r_opacity);
            r2_last    <= r1_last;
        end
        if (ctl.en_s3) begin
            r3_ang   <= r2_ang;
            r3_size  <= n3_size;
            r3_alpha <= n3_alpha;
            r3_last  <= r2_last;
        end
        if (ctl.en_s4) begin
            r4_ang   <= r3_ang;
            r4_size  <= r3_size;
            r4_alpha <= r3_alpha;
            r4_last  <= r3_last;
        end
        if (ctl.en_s5) begin
            r5_ang   <= r4_ang;
            r5_size  <= r4_size;
            r5_alpha <= r4_alpha;
            r5_last  <= r4_last;
        end
    end

    assign o_m_tvalid = r_v5;
    assign o_m_tlast  = r5_last;
    assign o_m_tdata  = psat_pkg::TDATA_W'({r5_alpha, r5_size, r5_ang,
                                             res_vy, res_vx, res_y, res_x});

endmodule

// ----- hw/rtl/psat_checker.sv -----
// ----------------------------------------------------------------------------
// psat_checker
// Port-level checks on the point sprite affine transform, bound to the top.
// ----------------------------------------------------------------------------
module psat_checker #(
    parameter int FRACTION_BITS = psat_pkg::FRACTION_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic [psat_pkg::TDATA_W-1:0]  o_m_tdata,
    input logic                          o_m_tvalid,
    input logic                          o_m_tlast,
    input logic                          i_m_tready
);

    localparam int ALPHA_LO = 4 * psat_pkg::COORD_W + psat_pkg::ANGLE_W
                              + psat_pkg::SIZE_W;
    localparam int SIZE_LO  = 4 * psat_pkg::COORD_W + psat_pkg::ANGLE_W;
    localparam logic [psat_pkg::SIZE_W-1:0] SIZE_MAX =
        psat_pkg::SIZE_W'(16 << FRACTION_BITS);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output item valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("stalled output item changed or dropped");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[psat_pkg::FIELDS_W-1:ALPHA_LO]
                       <= psat_pkg::ALPHA_W'(psat_pkg::ALPHA_ONE))
        else $error("new_alpha above one");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (FRACTION_BITS <= 16)
            |-> o_m_tdata[ALPHA_LO-1:SIZE_LO] <= SIZE_MAX)
        else $error("new_size above limit");

endmodule

bind point_sprite_affine_transform_top psat_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_psat_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_m_tdata(o_m_tdata),
    .o_m_tvalid(o_m_tvalid),
    .o_m_tlast(o_m_tlast),
    .i_m_tready(i_m_tready)
);
